/* sv/triangle_transform_light_project_core_defines.svh */
// Assertion macros shared by the triangle transform RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TRIANGLE_TRANSFORM_LIGHT_PROJECT_CORE_DEFINES_SVH
`define TRIANGLE_TRANSFORM_LIGHT_PROJECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTLP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ttlp assertion failed");

// Next-cycle implication, disabled during reset.
`define TTLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ttlp assertion failed");

`endif

/* sv/ttlp_pkg.sv */
// Types, constants and fixed-point helpers for the triangle transform pipeline.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package ttlp_pkg;

   localparam int SCREEN_WIDTH  = 256;
   localparam int SCREEN_HEIGHT = 256;

   // Pipeline stage numbers, stage 0 being the input register.
   localparam int LANE_OUT_STAGE = 52;
   localparam int NRM_OUT_STAGE  = 14;
   localparam int SHADE_DELAY    = LANE_OUT_STAGE - NRM_OUT_STAGE;
   localparam int PIPE_DEPTH     = LANE_OUT_STAGE + 2;
   localparam int DIV_STAGES     = 42;
   localparam int NUM_LANES      = 3;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_ANGLE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_ANGLE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEPTH_OFFSET = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROJ_X_SCALE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROJ_Y_SCALE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROJ_Z_SCALE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROJ_Z_BIAS  = 3'd6;

   typedef struct packed {
      logic signed [17:0] cos_angle;
      logic signed [17:0] sin_angle;
      logic signed [31:0] depth_offset;
      logic signed [31:0] proj_x_scale;
      logic signed [31:0] proj_y_scale;
      logic signed [31:0] proj_z_scale;
      logic signed [31:0] proj_z_bias;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      cos_angle:    18'sd65536,
      sin_angle:    18'sd0,
      depth_offset: 32'sd1376256,
      proj_x_scale: 32'sd65536,
      proj_y_scale: 32'sd65536,
      proj_z_scale: 32'sd65543,
      proj_z_bias:  -32'sd6554
   };

   localparam logic signed [41:0] PRJ_LIMIT = 42'sh100_0000_0000;
   localparam logic signed [13:0] SCR_W = 14'(SCREEN_WIDTH);
   localparam logic signed [13:0] SCR_H = 14'(SCREEN_HEIGHT);

   function automatic logic signed [31:0] sat32(logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // floor(acc / 2^16) saturated to 32 bits
   function automatic logic signed [31:0] lin_round(logic signed [51:0] acc);
      logic signed [51:0] sh;
      sh = acc >>> 16;
      return sat32(66'(sh));
   endfunction

   // One restoring step: returns {quotient bit, new remainder}.
   function automatic logic [32:0] div_step(logic [31:0] rem, logic nb, logic [31:0] den);
      logic [32:0] trial;
      trial = {rem, nb};
      if (trial >= {1'b0, den}) begin
         return {1'b1, 32'(trial - {1'b0, den})};
      end
      return {1'b0, trial[31:0]};
   endfunction

   // Quotient or raw value, clamped to +/- 2^40.
   function automatic logic signed [41:0] resolve_xy(logic wz, logic ovf, logic neg,
                                                     logic [41:0] q, logic signed [48:0] raw);
      if (wz) begin
         if (raw > 49'(PRJ_LIMIT)) return PRJ_LIMIT;
         if (raw < -49'(PRJ_LIMIT)) return -PRJ_LIMIT;
         return raw[41:0];
      end
      if (ovf || q > PRJ_LIMIT) begin
         return neg ? -PRJ_LIMIT : PRJ_LIMIT;
      end
      return neg ? -$signed(q) : $signed(q);
   endfunction

   // Quotient or raw value, saturated to 32 bits.
   function automatic logic signed [31:0] resolve_z(logic wz, logic ovf, logic neg,
                                                    logic [41:0] q, logic signed [48:0] raw);
      logic signed [42:0] qs;
      qs = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (wz) return sat32(66'(raw));
      if (ovf) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      return sat32(66'(qs));
   endfunction

   // floor((c + 1.0) * size / 2) saturated to 32 bits
   function automatic logic signed [31:0] screen_map(logic signed [41:0] c,
                                                     logic signed [13:0] size);
      logic signed [42:0] t;
      logic signed [56:0] prod;
      t = 43'(c) + 43'sd65536;
      prod = 57'(t) * 57'(size);
      return sat32(66'(prod >>> 1));
   endfunction

endpackage
`default_nettype wire

/* sv/ttlp_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on ttlp_pkg for the step function and stage count.
`default_nettype none
module ttlp_divider import ttlp_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic [64:0]        num_mag,
   input  logic [31:0]        den,
   input  logic               neg,
   input  logic               wz,
   input  logic signed [48:0] raw,
   output logic [41:0]        q_out,
   output logic               ovf_out,
   output logic               neg_out,
   output logic               wz_out,
   output logic signed [48:0] raw_out
);

   logic [31:0]        rem_ff [0:DIV_STAGES-1];
   logic [41:0]        num_ff [0:DIV_STAGES-1];
   logic [41:0]        q_ff   [0:DIV_STAGES-1];
   logic [31:0]        den_ff [0:DIV_STAGES-1];
   logic               ovf_ff [0:DIV_STAGES-1];
   logic               neg_ff [0:DIV_STAGES-1];
   logic               wz_ff  [0:DIV_STAGES-1];
   logic signed [48:0] raw_ff [0:DIV_STAGES-1];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [31:0]        rem_src;
      logic [41:0]        num_src;
      logic [41:0]        q_src;
      logic [31:0]        den_src;
      logic               ovf_src;
      logic               neg_src;
      logic               wz_src;
      logic signed [48:0] raw_src;
      logic               nb;
      logic [32:0]        step;

      if (g == 0) begin : g_first
         // quotient at or above 2^42 saturates downstream
         assign rem_src = 32'(num_mag[64:42]);
         assign num_src = num_mag[41:0];
         assign q_src   = '0;
         assign den_src = den;
         assign ovf_src = (32'(num_mag[64:42]) >= den);
         assign neg_src = neg;
         assign wz_src  = wz;
         assign raw_src = raw;
      end else begin : g_rest
         assign rem_src = rem_ff[g-1];
         assign num_src = num_ff[g-1];
         assign q_src   = q_ff[g-1];
         assign den_src = den_ff[g-1];
         assign ovf_src = ovf_ff[g-1];
         assign neg_src = neg_ff[g-1];
         assign wz_src  = wz_ff[g-1];
         assign raw_src = raw_ff[g-1];
      end

      assign nb   = num_src[DIV_STAGES-1-g];
      assign step = div_step(rem_src, nb, den_src);

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[g] <= step[31:0];
            num_ff[g] <= num_src;
            q_ff[g]   <= {q_src[40:0], step[32]};
            den_ff[g] <= den_src;
            ovf_ff[g] <= ovf_src;
            neg_ff[g] <= neg_src;
            wz_ff[g]  <= wz_src;
            raw_ff[g] <= raw_src;
         end
      end
   end

   assign q_out   = q_ff[DIV_STAGES-1];
   assign ovf_out = ovf_ff[DIV_STAGES-1];
   assign neg_out = neg_ff[DIV_STAGES-1];
   assign wz_out  = wz_ff[DIV_STAGES-1];
   assign raw_out = raw_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

/* sv/ttlp_vertex_lane.sv */
// One vertex lane: rotate, offset depth, project, divide by w and map to screen.
// Depends on ttlp_pkg and ttlp_divider.
`default_nettype none
module ttlp_vertex_lane import ttlp_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  cfg_type            cfg,
   input  logic signed [31:0] vx,
   input  logic signed [31:0] vy,
   input  logic signed [31:0] vz,
   output logic signed [31:0] p_out [0:2],
   output logic signed [31:0] sx,
   output logic signed [31:0] sy,
   output logic signed [31:0] sz
);

   logic signed [18:0] c19;
   logic signed [18:0] s19;
   logic signed [18:0] ns19;

   assign c19  = 19'(cfg.cos_angle);
   assign s19  = 19'(cfg.sin_angle);
   assign ns19 = -s19;

   logic signed [31:0] x0_ff, y0_ff, z0_ff;
   logic signed [50:0] m_xc1_ff, m_ys1_ff, m_xs1_ff, m_yc1_ff;
   logic signed [31:0] z1_ff;
   logic signed [31:0] zx2_ff, zy2_ff, z2_ff;
   logic signed [50:0] m_yc3_ff, m_zs3_ff, m_ys3_ff, m_zc3_ff;
   logic signed [31:0] zx3_ff;
   logic signed [31:0] zx4_ff, xy4_ff, xz4_ff;
   logic signed [31:0] p5_ff [0:2];
   logic signed [63:0] m6_ff [0:2];
   logic signed [31:0] w6_ff;
   logic signed [48:0] prj7_ff [0:2];
   logic signed [31:0] w7_ff;
   logic [64:0]        num8_ff [0:2];
   logic               neg8_ff [0:2];
   logic signed [48:0] raw8_ff [0:2];
   logic [31:0]        den8_ff;
   logic               wz8_ff;
   logic signed [41:0] cxy51_ff [0:1];
   logic signed [31:0] z51_ff;
   logic signed [31:0] sx_ff, sy_ff, sz_ff;

   logic [41:0]        dq   [0:2];
   logic               dovf [0:2];
   logic               dneg [0:2];
   logic               dwz  [0:2];
   logic signed [48:0] draw [0:2];

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff <= vx;
         y0_ff <= vy;
         z0_ff <= vz;
         // rotate about Z
         m_xc1_ff <= x0_ff * c19;
         m_ys1_ff <= y0_ff * ns19;
         m_xs1_ff <= x0_ff * s19;
         m_yc1_ff <= y0_ff * c19;
         z1_ff    <= z0_ff;
         zx2_ff   <= lin_round(52'(m_xc1_ff) + 52'(m_ys1_ff));
         zy2_ff   <= lin_round(52'(m_xs1_ff) + 52'(m_yc1_ff));
         z2_ff    <= z1_ff;
         // rotate about X
         m_yc3_ff <= zy2_ff * c19;
         m_zs3_ff <= z2_ff * ns19;
         m_ys3_ff <= zy2_ff * s19;
         m_zc3_ff <= z2_ff * c19;
         zx3_ff   <= zx2_ff;
         zx4_ff   <= zx3_ff;
         xy4_ff   <= lin_round(52'(m_yc3_ff) + 52'(m_zs3_ff));
         xz4_ff   <= lin_round(52'(m_ys3_ff) + 52'(m_zc3_ff));
         p5_ff[0] <= zx4_ff;
         p5_ff[1] <= xy4_ff;
         p5_ff[2] <= sat32(66'(33'(xz4_ff) + 33'(cfg.depth_offset)));
         // project
         m6_ff[0] <= p5_ff[0] * cfg.proj_x_scale;
         m6_ff[1] <= p5_ff[1] * cfg.proj_y_scale;
         m6_ff[2] <= p5_ff[2] * cfg.proj_z_scale;
         w6_ff    <= p5_ff[2];
         prj7_ff[0] <= 49'($signed(m6_ff[0][63:16]));
         prj7_ff[1] <= 49'($signed(m6_ff[1][63:16]));
         prj7_ff[2] <= 49'($signed(m6_ff[2][63:16])) + 49'(cfg.proj_z_bias);
         w7_ff      <= w6_ff;
         den8_ff    <= w7_ff[31] ? 32'(-w7_ff) : 32'(w7_ff);
         wz8_ff     <= (w7_ff == 32'sd0);
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [48:0] mag;
      assign mag = prj7_ff[ch][48] ? 49'(-prj7_ff[ch]) : 49'(prj7_ff[ch]);

      always_ff @(posedge clock) begin
         if (advance) begin
            num8_ff[ch] <= {mag, 16'b0};
            neg8_ff[ch] <= prj7_ff[ch][48] ^ w7_ff[31];
            raw8_ff[ch] <= prj7_ff[ch];
         end
      end

      ttlp_divider u_div (
         .clock   (clock),
         .advance (advance),
         .num_mag (num8_ff[ch]),
         .den     (den8_ff),
         .neg     (neg8_ff[ch]),
         .wz      (wz8_ff),
         .raw     (raw8_ff[ch]),
         .q_out   (dq[ch]),
         .ovf_out (dovf[ch]),
         .neg_out (dneg[ch]),
         .wz_out  (dwz[ch]),
         .raw_out (draw[ch])
      );

      if (ch < 2) begin : g_xy
         always_ff @(posedge clock) begin
            if (advance) begin
               cxy51_ff[ch] <= resolve_xy(dwz[ch], dovf[ch], dneg[ch], dq[ch], draw[ch]);
            end
         end
      end else begin : g_z
         always_ff @(posedge clock) begin
            if (advance) begin
               z51_ff <= resolve_z(dwz[ch], dovf[ch], dneg[ch], dq[ch], draw[ch]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sx_ff <= screen_map(cxy51_ff[0], SCR_W);
         sy_ff <= screen_map(cxy51_ff[1], SCR_H);
         sz_ff <= z51_ff;
      end
   end

   assign p_out = p5_ff;
   assign sx = sx_ff;
   assign sy = sy_ff;
   assign sz = sz_ff;

endmodule
`default_nettype wire

/* sv/ttlp_normal_unit.sv */
// Face normal, back-face cull and flat shade from the three rotated vertices.
// Depends on ttlp_pkg.
`default_nettype none
module ttlp_normal_unit import ttlp_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic signed [31:0] p0 [0:2],
   input  logic signed [31:0] p1 [0:2],
   input  logic signed [31:0] p2 [0:2],
   output logic               visible,
   output logic signed [4:0]  shade
);

   logic signed [31:0] e1_ff [0:2], e2_ff [0:2];
   logic signed [31:0] q6_ff [0:2], q7_ff [0:2], q8_ff [0:2], q9_ff [0:2];
   logic signed [31:0] q10_ff [0:2], q11_ff [0:2];
   logic signed [63:0] pa_ff [0:2], pb_ff [0:2];
   logic signed [64:0] n_ff [0:2];
   logic [63:0]        mag9_ff [0:2], mag10_ff [0:2];
   logic               sgn9_ff [0:2], sgn10_ff [0:2];
   logic [63:0]        orm_ff;
   logic [5:0]         sh_ff;
   logic signed [25:0] r_ff [0:2];
   logic [24:0]        rmag_ff [0:2];
   logic signed [57:0] dot_ff [0:2];
   logic [49:0]        sq_ff [0:2];
   logic               rz_neg12_ff, rz_neg13_ff;
   logic               vis13_ff, vis14_ff;
   logic [51:0]        n2_ff;
   logic [57:0]        q13_ff;
   logic signed [4:0]  shade14_ff;

   logic [6:0] bitlen;
   logic [3:0] kcount;

   always_comb begin
      bitlen = '0;
      for (int i = 0; i < 64; i++) begin
         if (orm_ff[i]) bitlen = 7'(i + 1);
      end
   end

   // k*k*|N|^2 grows with k, so the count of passing k is the largest one
   always_comb begin
      kcount = '0;
      for (int k = 1; k <= 13; k++) begin
         if (60'(k * k) * 60'(n2_ff) <= 60'(q13_ff)) kcount = kcount + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j < 3; j++) begin
            e1_ff[j] <= 32'((33'(p1[j]) - 33'(p0[j])) >>> 1);
            e2_ff[j] <= 32'((33'(p2[j]) - 33'(p0[j])) >>> 1);
         end
         q6_ff <= p0;
         pa_ff[0] <= e1_ff[1] * e2_ff[2];
         pb_ff[0] <= e1_ff[2] * e2_ff[1];
         pa_ff[1] <= e1_ff[2] * e2_ff[0];
         pb_ff[1] <= e1_ff[0] * e2_ff[2];
         pa_ff[2] <= e1_ff[0] * e2_ff[1];
         pb_ff[2] <= e1_ff[1] * e2_ff[0];
         q7_ff <= q6_ff;
         for (int j = 0; j < 3; j++) begin
            n_ff[j] <= 65'(pa_ff[j]) - 65'(pb_ff[j]);
         end
         q8_ff <= q7_ff;
         for (int j = 0; j < 3; j++) begin
            mag9_ff[j] <= n_ff[j][64] ? 64'(-n_ff[j]) : 64'(n_ff[j]);
            sgn9_ff[j] <= n_ff[j][64];
         end
         // highest set bit of the OR equals that of the largest magnitude
         orm_ff <= (n_ff[0][64] ? 64'(-n_ff[0]) : 64'(n_ff[0]))
                 | (n_ff[1][64] ? 64'(-n_ff[1]) : 64'(n_ff[1]))
                 | (n_ff[2][64] ? 64'(-n_ff[2]) : 64'(n_ff[2]));
         q9_ff <= q8_ff;
         sh_ff <= (bitlen > 7'd25) ? 6'(bitlen - 7'd25) : 6'd0;
         mag10_ff <= mag9_ff;
         sgn10_ff <= sgn9_ff;
         q10_ff <= q9_ff;
         for (int j = 0; j < 3; j++) begin
            rmag_ff[j] <= 25'(mag10_ff[j] >> sh_ff);
            r_ff[j] <= sgn10_ff[j] ? -$signed({1'b0, 25'(mag10_ff[j] >> sh_ff)})
                                   : $signed({1'b0, 25'(mag10_ff[j] >> sh_ff)});
         end
         q11_ff <= q10_ff;
         for (int j = 0; j < 3; j++) begin
            dot_ff[j] <= r_ff[j] * q11_ff[j];
            sq_ff[j]  <= rmag_ff[j] * rmag_ff[j];
         end
         rz_neg12_ff <= r_ff[2][25];
         vis13_ff    <= (60'(dot_ff[0]) + 60'(dot_ff[1]) + 60'(dot_ff[2])) < 60'sd0;
         n2_ff       <= 52'(sq_ff[0]) + 52'(sq_ff[1]) + 52'(sq_ff[2]);
         q13_ff      <= 58'(sq_ff[2]) * 58'd169;
         rz_neg13_ff <= rz_neg12_ff;
         vis14_ff    <= vis13_ff;
         shade14_ff  <= rz_neg13_ff ? $signed(5'(kcount)) : -$signed(5'(kcount));
      end
   end

   assign visible = vis14_ff;
   assign shade   = shade14_ff;

endmodule
`default_nettype wire

/* sv/ttlp_merge.sv */
// Merge stage: aligns the cull and shade result with the lane outputs.
// Depends on ttlp_pkg; zeroes every field of a hidden face.
`default_nettype none
module ttlp_merge import ttlp_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic               vis_in,
   input  logic signed [4:0]  shade_in,
   input  logic signed [31:0] lane_sx [0:NUM_LANES-1],
   input  logic signed [31:0] lane_sy [0:NUM_LANES-1],
   input  logic signed [31:0] lane_sz [0:NUM_LANES-1],
   output logic               visible,
   output logic signed [4:0]  shade_level,
   output logic signed [31:0] sx [0:NUM_LANES-1],
   output logic signed [31:0] sy [0:NUM_LANES-1],
   output logic signed [31:0] sz [0:NUM_LANES-1]
);

   logic              vis_dly_ff   [0:SHADE_DELAY-1];
   logic signed [4:0] shade_dly_ff [0:SHADE_DELAY-1];
   logic              visible_ff;
   logic signed [4:0] shade_ff;
   logic signed [31:0] sx_ff [0:NUM_LANES-1];
   logic signed [31:0] sy_ff [0:NUM_LANES-1];
   logic signed [31:0] sz_ff [0:NUM_LANES-1];
   logic              vis_now;

   assign vis_now = vis_dly_ff[SHADE_DELAY-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         vis_dly_ff[0]   <= vis_in;
         shade_dly_ff[0] <= shade_in;
         for (int i = 1; i < SHADE_DELAY; i++) begin
            vis_dly_ff[i]   <= vis_dly_ff[i-1];
            shade_dly_ff[i] <= shade_dly_ff[i-1];
         end
         visible_ff <= vis_now;
         shade_ff   <= vis_now ? shade_dly_ff[SHADE_DELAY-1] : 5'sd0;
         for (int i = 0; i < NUM_LANES; i++) begin
            sx_ff[i] <= vis_now ? lane_sx[i] : 32'sd0;
            sy_ff[i] <= vis_now ? lane_sy[i] : 32'sd0;
            sz_ff[i] <= vis_now ? lane_sz[i] : 32'sd0;
         end
      end
   end

   assign visible     = visible_ff;
   assign shade_level = shade_ff;
   assign sx = sx_ff;
   assign sy = sy_ff;
   assign sz = sz_ff;

endmodule
`default_nettype wire

/* sv/triangle_transform_light_project_core.sv */
// Top level of the triangle transform, cull, shade and projection pipeline.
// Depends on ttlp_pkg, ttlp_vertex_lane, ttlp_normal_unit, ttlp_merge and the defines header.
//
// One triangle request enters per clock unless the pipeline holds: three vertex
// lanes rotate and project the vertices in parallel, each running its three divisions by w
// through a 42-stage one-bit-per-stage divider pipeline, while a normal unit culls and
// shades the face and a merge stage joins the two. The whole pipeline holds while a
// finished result is not taken, so throughput is one triangle per cycle whenever the
// response side keeps up. Configuration writes take effect at once and are meant for an
// empty pipeline.
`default_nettype none
`include "triangle_transform_light_project_core_defines.svh"
module triangle_transform_light_project_core import ttlp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_ax,
   input  logic signed [31:0]     req_ay,
   input  logic signed [31:0]     req_az,
   input  logic signed [31:0]     req_bx,
   input  logic signed [31:0]     req_by_coord,
   input  logic signed [31:0]     req_bz,
   input  logic signed [31:0]     req_cx,
   input  logic signed [31:0]     req_cy,
   input  logic signed [31:0]     req_cz,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_visible,
   output logic signed [4:0]      rsp_shade_level,
   output logic signed [31:0]     rsp_sx0,
   output logic signed [31:0]     rsp_sy0,
   output logic signed [31:0]     rsp_sz0,
   output logic signed [31:0]     rsp_sx1,
   output logic signed [31:0]     rsp_sy1,
   output logic signed [31:0]     rsp_sz1,
   output logic signed [31:0]     rsp_sx2,
   output logic signed [31:0]     rsp_sy2,
   output logic signed [31:0]     rsp_sz2
);

   cfg_type cfg_ff, cfg_in;
   logic [PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic advance;

   logic signed [31:0] vin_x [0:NUM_LANES-1];
   logic signed [31:0] vin_y [0:NUM_LANES-1];
   logic signed [31:0] vin_z [0:NUM_LANES-1];
   logic signed [31:0] p0 [0:2], p1 [0:2], p2 [0:2];
   logic signed [31:0] lane_sx [0:NUM_LANES-1];
   logic signed [31:0] lane_sy [0:NUM_LANES-1];
   logic signed [31:0] lane_sz [0:NUM_LANES-1];
   logic signed [31:0] out_sx [0:NUM_LANES-1];
   logic signed [31:0] out_sy [0:NUM_LANES-1];
   logic signed [31:0] out_sz [0:NUM_LANES-1];
   logic               nrm_vis;
   logic signed [4:0]  nrm_shade;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_COS_ANGLE:    cfg_in.cos_angle    = csr_write_data[17:0];
            CSR_SIN_ANGLE:    cfg_in.sin_angle    = csr_write_data[17:0];
            CSR_DEPTH_OFFSET: cfg_in.depth_offset = csr_write_data;
            CSR_PROJ_X_SCALE: cfg_in.proj_x_scale = csr_write_data;
            CSR_PROJ_Y_SCALE: cfg_in.proj_y_scale = csr_write_data;
            CSR_PROJ_Z_SCALE: cfg_in.proj_z_scale = csr_write_data;
            CSR_PROJ_Z_BIAS:  cfg_in.proj_z_bias  = csr_write_data;
            default: ;
         endcase
      end
   end

   // hold every stage while the finished result waits
   assign advance   = !valid_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[PIPE_DEPTH-1];
   assign valid_in  = advance ? {valid_ff[PIPE_DEPTH-2:0], req_valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         valid_ff <= '0;
      end else begin
         cfg_ff   <= cfg_in;
         valid_ff <= valid_in;
      end
   end

   assign vin_x[0] = req_ax;
   assign vin_y[0] = req_ay;
   assign vin_z[0] = req_az;
   assign vin_x[1] = req_bx;
   assign vin_y[1] = req_by_coord;
   assign vin_z[1] = req_bz;
   assign vin_x[2] = req_cx;
   assign vin_y[2] = req_cy;
   assign vin_z[2] = req_cz;

   ttlp_vertex_lane u_lane0 (
      .clock (clock), .advance (advance), .cfg (cfg_ff),
      .vx (vin_x[0]), .vy (vin_y[0]), .vz (vin_z[0]),
      .p_out (p0), .sx (lane_sx[0]), .sy (lane_sy[0]), .sz (lane_sz[0])
   );

   ttlp_vertex_lane u_lane1 (
      .clock (clock), .advance (advance), .cfg (cfg_ff),
      .vx (vin_x[1]), .vy (vin_y[1]), .vz (vin_z[1]),
      .p_out (p1), .sx (lane_sx[1]), .sy (lane_sy[1]), .sz (lane_sz[1])
   );

   ttlp_vertex_lane u_lane2 (
      .clock (clock), .advance (advance), .cfg (cfg_ff),
      .vx (vin_x[2]), .vy (vin_y[2]), .vz (vin_z[2]),
      .p_out (p2), .sx (lane_sx[2]), .sy (lane_sy[2]), .sz (lane_sz[2])
   );

   ttlp_normal_unit u_normal (
      .clock   (clock),
      .advance (advance),
      .p0      (p0),
      .p1      (p1),
      .p2      (p2),
      .visible (nrm_vis),
      .shade   (nrm_shade)
   );

   ttlp_merge u_merge (
      .clock       (clock),
      .advance     (advance),
      .vis_in      (nrm_vis),
      .shade_in    (nrm_shade),
      .lane_sx     (lane_sx),
      .lane_sy     (lane_sy),
      .lane_sz     (lane_sz),
      .visible     (rsp_visible),
      .shade_level (rsp_shade_level),
      .sx          (out_sx),
      .sy          (out_sy),
      .sz          (out_sz)
   );

   assign rsp_sx0 = out_sx[0];
   assign rsp_sy0 = out_sy[0];
   assign rsp_sz0 = out_sz[0];
   assign rsp_sx1 = out_sx[1];
   assign rsp_sy1 = out_sy[1];
   assign rsp_sz1 = out_sz[1];
   assign rsp_sx2 = out_sx[2];
   assign rsp_sy2 = out_sy[2];
   assign rsp_sz2 = out_sz[2];

   `TTLP_ASSERT_NEXT(a_stall_freezes_pipe, !req_ready, $stable(valid_ff))
   `TTLP_ASSERT_IMPL(a_hidden_face_zero, rsp_valid && !rsp_visible,
      rsp_shade_level == 5'sd0 && rsp_sx0 == 32'sd0 && rsp_sy1 == 32'sd0 && rsp_sz2 == 32'sd0)
   `TTLP_ASSERT_IMPL(a_shade_range, rsp_valid,
      rsp_shade_level >= -5'sd13 && rsp_shade_level <= 5'sd13)

endmodule
`default_nettype wire

/* bench/triangle_transform_light_project_core_tb.sv */
// Testbench for the triangle transform, cull, shade and projection core.
// Depends on ttlp_pkg and triangle_transform_light_project_core; checks results
// against a behavioral predictor across register settings and flow-control modes.
`default_nettype none
module triangle_transform_light_project_core_tb;
   import ttlp_pkg::*;

   typedef logic [8:0][31:0] tri_type;
   typedef struct packed {
      logic            vis;
      logic [4:0]      shade;
      logic [8:0][31:0] scr;
   } shaded_face_type;

   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 16;
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_COS_ANGLE;
   logic [31:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_ax = '0, req_ay = '0, req_az = '0;
   logic signed [31:0] req_bx = '0, req_by_coord = '0, req_bz = '0;
   logic signed [31:0] req_cx = '0, req_cy = '0, req_cz = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_visible;
   logic signed [4:0] rsp_shade_level;
   logic signed [31:0] rsp_sx0, rsp_sy0, rsp_sz0, rsp_sx1, rsp_sy1, rsp_sz1;
   logic signed [31:0] rsp_sx2, rsp_sy2, rsp_sz2;

   triangle_transform_light_project_core dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_ax(req_ax), .req_ay(req_ay), .req_az(req_az),
      .req_bx(req_bx), .req_by_coord(req_by_coord), .req_bz(req_bz),
      .req_cx(req_cx), .req_cy(req_cy), .req_cz(req_cz),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_visible(rsp_visible), .rsp_shade_level(rsp_shade_level),
      .rsp_sx0(rsp_sx0), .rsp_sy0(rsp_sy0), .rsp_sz0(rsp_sz0),
      .rsp_sx1(rsp_sx1), .rsp_sy1(rsp_sy1), .rsp_sz1(rsp_sz1),
      .rsp_sx2(rsp_sx2), .rsp_sy2(rsp_sy2), .rsp_sz2(rsp_sz2)
   );

   // Register shadow used by the predictor
   longint cos_q, sin_q, depth_q, xs_q, ys_q, zs_q, zb_q;

   shaded_face_type pending_faces[$];
   bit failed = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_reqs = 0;
   int hold_done = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_32(longint v);
      return clamp(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint rotate_term(longint a, longint c, longint b, longint d);
      return sat_32((a * c + b * d) >>> 16);
   endfunction

   function automatic longint to_pixel(longint v, longint size);
      v = clamp(v, -64'sd1099511627776, 64'sd1099511627776);
      return sat_32(((v + 65536) * size) >>> 1);
   endfunction

   function automatic shaded_face_type shade_and_project(tri_type t);
      longint p[3][3];
      longint e1[3], e2[3], n[3], r[3];
      longint x, y, z, zy, w, m, mg, n2, q, k;
      int sh;
      shaded_face_type f;
      f = '0;
      for (int i = 0; i < 3; i++) begin
         x = longint'($signed(t[i*3]));
         y = longint'($signed(t[i*3+1]));
         z = longint'($signed(t[i*3+2]));
         p[i][0] = rotate_term(x, cos_q, y, -sin_q);
         zy = rotate_term(x, sin_q, y, cos_q);
         p[i][1] = rotate_term(zy, cos_q, z, -sin_q);
         p[i][2] = sat_32(rotate_term(zy, sin_q, z, cos_q) + depth_q);
      end
      for (int j = 0; j < 3; j++) begin
         e1[j] = (p[1][j] - p[0][j]) >>> 1;
         e2[j] = (p[2][j] - p[0][j]) >>> 1;
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      m = 0;
      for (int j = 0; j < 3; j++) begin
         mg = n[j] < 0 ? -n[j] : n[j];
         if (mg > m) m = mg;
      end
      sh = 0;
      while ((m >> sh) > 64'h1FF_FFFF) sh++;
      for (int j = 0; j < 3; j++) begin
         mg = (n[j] < 0 ? -n[j] : n[j]) >> sh;
         r[j] = n[j] < 0 ? -mg : mg;
      end
      f.vis = (r[0] * p[0][0] + r[1] * p[0][1] + r[2] * p[0][2]) < 0;
      if (!f.vis) return f;
      n2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
      q = 169 * r[2] * r[2];
      for (k = 13; k > 0; k--) begin
         if (k * k * n2 <= q) break;
      end
      f.shade = 5'(r[2] < 0 ? k : -k);
      for (int i = 0; i < 3; i++) begin
         w = p[i][2];
         x = (p[i][0] * xs_q) >>> 16;
         y = (p[i][1] * ys_q) >>> 16;
         z = ((p[i][2] * zs_q) >>> 16) + zb_q;
         if (w != 0) begin
            x = (x * 65536) / w;
            y = (y * 65536) / w;
            z = (z * 65536) / w;
         end
         f.scr[i*3]   = 32'(to_pixel(x, SCREEN_WIDTH));
         f.scr[i*3+1] = 32'(to_pixel(y, SCREEN_HEIGHT));
         f.scr[i*3+2] = 32'(sat_32(z));
      end
      return f;
   endfunction

   // Hold off for a counted stretch, otherwise stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_done != hold_reqs) begin
         hold_done <= hold_reqs;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      shaded_face_type want;
      logic [8:0][31:0] got;
      string names[9];
      names = '{"sx0", "sy0", "sz0", "sx1", "sy1", "sz1", "sx2", "sy2", "sz2"};
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_sz2, rsp_sy2, rsp_sx2, rsp_sz1, rsp_sy1, rsp_sx1,
                rsp_sz0, rsp_sy0, rsp_sx0};
         if (pending_faces.size() == 0) begin
            $error("result with no request outstanding");
            failed = 1;
         end else begin
            want = pending_faces.pop_front();
            if (rsp_visible !== want.vis) begin
               $error("visible exp %0d got %0d", want.vis, rsp_visible);
               failed = 1;
            end
            if (rsp_shade_level !== want.shade) begin
               $error("shade_level exp %0d got %0d", $signed(want.shade), rsp_shade_level);
               failed = 1;
            end
            for (int i = 0; i < 9; i++) begin
               if (got[i] !== want.scr[i]) begin
                  $error("%s exp %0d got %0d", names[i], $signed(want.scr[i]),
                         $signed(got[i]));
                  failed = 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("triangle_transform_light_project_core_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_COS_ANGLE:    cos_q = longint'($signed(data[17:0]));
         CSR_SIN_ANGLE:    sin_q = longint'($signed(data[17:0]));
         CSR_DEPTH_OFFSET: depth_q = longint'($signed(data));
         CSR_PROJ_X_SCALE: xs_q = longint'($signed(data));
         CSR_PROJ_Y_SCALE: ys_q = longint'($signed(data));
         CSR_PROJ_Z_SCALE: zs_q = longint'($signed(data));
         CSR_PROJ_Z_BIAS:  zb_q = longint'($signed(data));
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_all_regs(input logic [17:0] c, input logic [17:0] s,
                               input logic [31:0] d, input logic [31:0] xs,
                               input logic [31:0] ys, input logic [31:0] zs,
                               input logic [31:0] zb);
      write_reg(CSR_COS_ANGLE, 32'($signed(c)));
      write_reg(CSR_SIN_ANGLE, 32'($signed(s)));
      write_reg(CSR_DEPTH_OFFSET, d);
      write_reg(CSR_PROJ_X_SCALE, xs);
      write_reg(CSR_PROJ_Y_SCALE, ys);
      write_reg(CSR_PROJ_Z_SCALE, zs);
      write_reg(CSR_PROJ_Z_BIAS, zb);
   endtask

   task automatic send_tri(input tri_type t);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      {req_cz, req_cy, req_cx, req_bz, req_by_coord, req_bx, req_az, req_ay, req_ax} <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_faces = {pending_faces, shade_and_project(t)};
   endtask

   // Wait for every outstanding result, then let the pipeline settle
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_faces.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(input int span_log2);
      int mag;
      mag = $urandom_range((1 << span_log2) - 1);
      return $urandom_range(1) ? 32'(-mag) : 32'(mag);
   endfunction

   function automatic tri_type rand_tri();
      tri_type t;
      int pick;
      pick = $urandom_range(99);
      for (int i = 0; i < 9; i++) begin
         if (pick < 70) t[i] = rand_coord(20);        // within +/-16.0
         else if (pick < 85) t[i] = rand_coord(28);
         else t[i] = $urandom;
      end
      return t;
   endfunction

   task automatic test_directed;
      tri_type t;
      logic [31:0] one;
      one = 32'sd65536;
      send_tri('0);                                        // degenerate: all zero
      send_tri({32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0});
      send_tri({32'sd0, 32'sd0, one, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
      // w of zero on the first vertex under the reset settings: z placed at -depth_offset
      t = {32'sd0, one, one, 32'sd0, -one, one, -32'sd1376256, 32'sd0, 32'sd0};
      send_tri(t);
      t = {32'sd0, -one, one, 32'sd0, one, one, -32'sd1376256, 32'sd0, 32'sd0};
      send_tri(t);
      send_tri({9{32'h7fff_ffff}});
      send_tri({9{32'h8000_0000}});
      send_tri({9{32'hffff_ffff}});
      send_tri({32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
      send_tri({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff});
      // collinear vertices
      send_tri({32'sd0, 2 * one, 2 * one, 32'sd0, one, one, 32'sd0, 32'sd0, 32'sd0});
      // face seen face-on at depth, then a face whose first and last vertices coincide
      send_tri({-one, one, 32'sd0, -one, 32'sd0, one, -one, 32'sd0, 32'sd0});
      send_tri({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
      for (int i = 0; i < 8; i++) send_tri(rand_tri());
      drain();
   endtask

   task automatic test_random_setting(input int phase, input int count);
      case (phase % 4)
         0: begin send_idle_pct = 0; stall_pct = 0; end
         1: begin send_idle_pct = 52; stall_pct = 0; end
         2: begin send_idle_pct = 0; stall_pct = 52; end
         default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      for (int i = 0; i < count; i++) send_tri(rand_tri());
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_reqs = hold_reqs + 1;
      for (int i = 0; i < 80; i++) send_tri(rand_tri());
      drain();
   endtask

   initial begin
      cos_q = 65536; sin_q = 0; depth_q = 1376256;
      xs_q = 65536; ys_q = 65536; zs_q = 65543; zb_q = -6554;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_directed();
      test_random_setting(0, 100);
      // 45 degrees
      set_all_regs(18'sd46341, 18'sd46341, 32'sd1376256, 32'sd65536, 32'sd65536,
                   32'sd65543, -32'sd6554);
      test_random_setting(1, 100);
      test_directed();
      // extremes of the documented ranges
      set_all_regs(-18'sd65536, 18'sd65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h8000_0000);
      test_random_setting(2, 100);
      set_all_regs(18'sd65536, -18'sd65536, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h7fff_ffff);
      test_random_setting(3, 100);
      // out-of-range angle terms, small projection terms
      set_all_regs(18'h1ffff, 18'h20000, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0);
      test_random_setting(0, 60);
      set_all_regs(18'($urandom), 18'($urandom), $urandom, $urandom, $urandom, $urandom,
                   $urandom);
      test_random_setting(1, 60);
      set_all_regs(18'sd56756, -18'sd32768, 32'sd655360, 32'sd98304, 32'sd65536,
                   32'sd65543, -32'sd6554);
      test_random_setting(2, 80);
      test_backpressure();

      if (!failed) begin
         $display("triangle_transform_light_project_core_tb: PASS");
      end else begin
         $display("triangle_transform_light_project_core_tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
